@@ rtl/lspq_pkg.sv @@
// ----------------------------------------------------------------------------
// lspq_pkg
// Shared types and constants for the linear-scan job priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lspq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int JOB_W        = 54;
   localparam int LIMIT_W      = 7;
   localparam int OCC_W        = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = 7'd64;

   // word index of the configuration registers
   localparam logic REG_QUEUE_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic        func;
      logic [3:0]  in_priority;
      logic [2:0]  in_compute_time;
      logic [16:0] in_job_id;
      logic [7:0]  in_producer;
      logic [21:0] in_process;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  out_priority;
      logic [2:0]  out_compute_time;
      logic [16:0] out_job_id;
      logic [7:0]  out_producer;
      logic [21:0] out_process;
      logic [6:0]  occupancy;
   } rsp_type;

   // one stored job record, priority in the top bits
   typedef struct packed {
      logic [3:0]  pri;
      logic [2:0]  ctime;
      logic [16:0] job_id;
      logic [7:0]  producer;
      logic [21:0] proc;
   } job_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic insert;
      logic remove_start;
      logic scan;
      logic shift_start;
      logic shift;
      logic finish;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic issue_done;
      logic rd_busy;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/linear_scan_priority_queue_core.sv @@
// Insert, refused insert and empty remove: accepted in idle, then the reply state loads
//   the result once the output register is free. One transaction in flight at a time.
// Remove: one store read port sets the order: scan all held entries for the best one,
//   then close the gap by moving each later entry down one place.
// Reset clears the count and control state and sets queue_limit to 64; the job
//   store is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// linear_scan_priority_queue_core
// Job queue held in arrival order; remove returns the highest-priority job.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_scan_priority_queue_core #(
   parameter int CAPACITY = lspq_pkg::CAPACITY_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire lspq_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output lspq_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [lspq_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [lspq_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lspq_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   import lspq_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic               csr_wr;
   cmd_type            cmd;
   sts_type            sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= QUEUE_LIMIT_RESET;
      end else if (csr_wr && csr_paddr[CSR_ADDR_W-1] == REG_QUEUE_LIMIT) begin
         limit_ff <= csr_pwdata[LIMIT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_QUEUE_LIMIT) ?
                       CSR_DATA_W'(limit_ff) : '0;

   lspq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lspq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .limit     (limit_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/lspq_ram.sv @@
// ----------------------------------------------------------------------------
// lspq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lspq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/lspq_ctrl.sv @@
// ----------------------------------------------------------------------------
// lspq_ctrl
// Sequencer for insert, scan, shift and reply phases of the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lspq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_func,
   output logic                   req_ready,
   input  wire lspq_pkg::sts_type sts,
   output lspq_pkg::cmd_type      cmd
);

   import lspq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_func == FUNC_REMOVE && !sts.empty) begin
                  cmd.remove_start = 1'b1;
                  state_in         = ST_SCAN;
               end else begin
                  cmd.insert = (req_func == FUNC_INSERT);
                  state_in   = ST_REPLY;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.issue_done && !sts.rd_busy) begin
               cmd.shift_start = 1'b1;
               state_in        = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.issue_done && !sts.rd_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_REPLY;
            end
         end
         ST_REPLY: begin
            // hold until the output register is free
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/lspq_dpath.sv @@
// ----------------------------------------------------------------------------
// lspq_dpath
// Job store, count, scan for the best entry, gap closing and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lspq_dpath #(
   parameter int CAPACITY = lspq_pkg::CAPACITY_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lspq_pkg::req_type              req_data,
   input  wire logic [lspq_pkg::LIMIT_W-1:0]   limit,
   input  wire lspq_pkg::cmd_type              cmd,
   output lspq_pkg::sts_type                   sts,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output lspq_pkg::rsp_type                   rsp_data
);

   import lspq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rd_vld_ff;
   logic [AW-1:0] rd_addr_ff;
   job_type       best_ff;
   logic [AW-1:0] best_idx_ff;
   logic          best_vld_ff;
   logic          func_ff;
   status_type    status_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic          full;
   logic          more;
   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   job_type       wr_data;
   job_type       rd_job;
   job_type       new_job;
   logic          out_free;

   assign full = (32'(count_ff) >= 32'(limit)) || (32'(count_ff) >= CAPACITY);
   assign more = (ptr_ff < count_ff);
   assign rd_en = (cmd.scan || cmd.shift) && more;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign new_job = '{pri:      req_data.in_priority,
                      ctime:    req_data.in_compute_time,
                      job_id:   req_data.in_job_id,
                      producer: req_data.in_producer,
                      proc:     req_data.in_process};

   // insert appends at the tail; shift moves a returning entry down one place
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr_ff - AW'(1);
      wr_data = rd_job;
      if (cmd.insert && !full) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[AW-1:0];
         wr_data = new_job;
      end else if (cmd.shift && rd_vld_ff) begin
         wr_en = 1'b1;
      end
   end

   lspq_ram #(
      .WIDTH (JOB_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[AW-1:0]),
      .rd_data (rd_job)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.insert && !full) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.finish) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.remove_start) begin
         ptr_in = '0;
      end else if (cmd.shift_start) begin
         ptr_in = CW'(best_idx_ff) + CW'(1);
      end else if (rd_en) begin
         ptr_in = ptr_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ptr_ff    <= ptr_in;
         rd_vld_ff <= rd_en;
         if (cmd.remove_start) begin
            best_vld_ff <= 1'b0;
         end else if (cmd.scan && rd_vld_ff) begin
            best_vld_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= ptr_ff[AW-1:0];
      // strictly greater keeps the earliest entry on a tie
      if (cmd.scan && rd_vld_ff && (!best_vld_ff || rd_job.pri > best_ff.pri)) begin
         best_ff     <= rd_job;
         best_idx_ff <= rd_addr_ff;
      end
      if (cmd.accept) begin
         func_ff <= req_data.func;
         if (req_data.func == FUNC_REMOVE) begin
            status_ff <= (count_ff == '0) ? STATUS_EMPTY : STATUS_DONE;
         end else begin
            status_ff <= full ? STATUS_FULL : STATUS_DONE;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.status    <= status_ff;
         rsp_ff.occupancy <= OCC_W'(count_ff);
         if (func_ff == FUNC_REMOVE && status_ff == STATUS_DONE) begin
            rsp_ff.out_priority     <= best_ff.pri;
            rsp_ff.out_compute_time <= best_ff.ctime;
            rsp_ff.out_job_id       <= best_ff.job_id;
            rsp_ff.out_producer     <= best_ff.producer;
            rsp_ff.out_process      <= best_ff.proc;
         end else begin
            rsp_ff.out_priority     <= '0;
            rsp_ff.out_compute_time <= '0;
            rsp_ff.out_job_id       <= '0;
            rsp_ff.out_producer     <= '0;
            rsp_ff.out_process      <= '0;
         end
      end
   end

   assign sts.empty      = (count_ff == '0);
   assign sts.issue_done = !more;
   assign sts.rd_busy    = rd_vld_ff;
   assign sts.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAPACITY)
      else $error("job count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert && !full) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("accepted insert did not grow the count");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < count_ff) || (cmd.insert && CW'(wr_addr) == count_ff))
      else $error("store write outside held entries");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> out_free)
      else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

@@ test/linear_scan_priority_queue_core_tb.sv @@
// ----------------------------------------------------------------------------
// linear_scan_priority_queue_core_tb
// Self-checking bench for the job priority queue core. Insert and remove
// transactions flow through valid/ready channels with random gaps and stalls.
// A shadow job list predicts every reply, and the queue limit register is
// swept across several values, beyond capacity and zero among them.
// ----------------------------------------------------------------------------

module linear_scan_priority_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lspq_pkg::*;

   localparam int DEPTH          = CAPACITY_DEF;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_ITEMS    = 195;
   localparam int STALL_MAX      = 18;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_MAX     = 10;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * REG_QUEUE_LIMIT);

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   req_type  job_requests[$];
   rsp_type  expected_replies[$];
   job_type  held_jobs[$];
   logic [LIMIT_W-1:0] limit_shadow = QUEUE_LIMIT_RESET;
   rsp_type  reply_want;

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   req_gap_left  = 0;
   int   req_gap_max   = 0;
   int   rsp_gap_left  = 0;
   int   rsp_gap_max   = 0;
   int   rsp_hold_left = 0;
   int   rsp_draw;
   int   quiet_cycles  = 0;

   int errors       = 0;
   int reports      = 0;
   int n_insert     = 0;
   int n_full       = 0;
   int n_remove     = 0;
   int n_empty      = 0;
   int peak_occ     = 0;
   int limit_writes = 0;

   linear_scan_priority_queue_core #(
      .CAPACITY(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Shadow queue: append on insert, take the earliest highest priority on remove.
   function automatic rsp_type predict_reply(input req_type rq);
      rsp_type reply;
      job_type fresh;
      job_type taken;
      int      cap_limit;
      int      best;
      reply = '0;
      cap_limit = (limit_shadow > DEPTH) ? DEPTH : int'(limit_shadow);
      if (rq.func == FUNC_INSERT) begin
         if (held_jobs.size() >= cap_limit) begin
            reply.status = STATUS_FULL;
            n_full++;
         end else begin
            fresh.pri      = rq.in_priority;
            fresh.ctime    = rq.in_compute_time;
            fresh.job_id   = rq.in_job_id;
            fresh.producer = rq.in_producer;
            fresh.proc     = rq.in_process;
            held_jobs.push_back(fresh);
            reply.status = STATUS_DONE;
            n_insert++;
         end
      end else begin
         if (held_jobs.size() == 0) begin
            reply.status = STATUS_EMPTY;
            n_empty++;
         end else begin
            best = 0;
            for (int k = 1; k < held_jobs.size(); k++) begin
               if (held_jobs[k].pri > held_jobs[best].pri) best = k;
            end
            taken = held_jobs[best];
            held_jobs.delete(best);
            reply.status           = STATUS_DONE;
            reply.out_priority     = taken.pri;
            reply.out_compute_time = taken.ctime;
            reply.out_job_id       = taken.job_id;
            reply.out_producer     = taken.producer;
            reply.out_process      = taken.proc;
            n_remove++;
         end
      end
      reply.occupancy = OCC_W'(held_jobs.size());
      if (held_jobs.size() > peak_occ) peak_occ = held_jobs.size();
      return reply;
   endfunction

   function automatic void report_reply(input string what, input rsp_type want,
                                        input rsp_type got);
      errors++;
      if (reports < REPORT_MAX) begin
         reports++;
         $display("%0t %s: expected st=%0d pri=%0d ct=%0d id=%h prod=%h proc=%h occ=%0d",
                  $realtime, what, want.status, want.out_priority, want.out_compute_time,
                  want.out_job_id, want.out_producer, want.out_process, want.occupancy);
         $display("%0t %s:   actual st=%0d pri=%0d ct=%0d id=%h prod=%h proc=%h occ=%0d",
                  $realtime, what, got.status, got.out_priority, got.out_compute_time,
                  got.out_job_id, got.out_producer, got.out_process, got.occupancy);
      end
   endfunction

   function automatic req_type job_of(input func_type op, input logic [3:0] pri,
                                      input logic [2:0] ctime, input logic [16:0] id,
                                      input logic [7:0] prod, input logic [21:0] proc);
      req_type rq;
      rq.func            = op;
      rq.in_priority     = pri;
      rq.in_compute_time = ctime;
      rq.in_job_id       = id;
      rq.in_producer     = prod;
      rq.in_process      = proc;
      return rq;
   endfunction

   function automatic req_type random_job(input func_type op, input int pri_top);
      return job_of(op, 4'($urandom_range(0, pri_top)), 3'($urandom), 17'($urandom),
                    8'($urandom), 22'($urandom));
   endfunction

   // Bursts of mostly inserts, mostly removes or an even mix; a narrow priority
   // range now and then to force ties.
   task automatic queue_random_items(input int count, input bit fill_first);
      int left;
      int burst;
      int ins_pct;
      int pri_top;
      bit lead;
      left = count;
      lead = fill_first;
      while (left > 0) begin
         if (lead) begin
            burst   = 80;
            ins_pct = 95;
         end else begin
            burst = $urandom_range(4, 60);
            case ($urandom_range(0, 2))
               0: ins_pct = 90;
               1: ins_pct = 10;
               default: ins_pct = 50;
            endcase
         end
         lead = 1'b0;
         pri_top = ($urandom_range(0, 3) == 0) ? 1 : 15;
         if (burst > left) burst = left;
         for (int k = 0; k < burst; k++) begin
            job_requests.push_back(random_job(
               ($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE, pri_top));
         end
         left -= burst;
      end
   endtask

   task automatic wait_queue_idle();
      do @(posedge clock);
      while (job_requests.size() != 0 || req_valid || expected_replies.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_limit_readback(input logic [LIMIT_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      csr_access(1'b0, '0, got);
      if (got !== CSR_DATA_W'(want)) begin
         errors++;
         if (reports < REPORT_MAX) begin
            reports++;
            $display("%0t queue_limit readback: expected %0d, actual %0d",
                     $realtime, want, got);
         end
      end
   endtask

   task automatic set_queue_limit(input logic [LIMIT_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, CSR_DATA_W'(value), unused);
      check_limit_readback(value);
   endtask

   // Sender: hold each transaction until taken, then idle for the drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap_left > 0) begin
            req_valid    <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (job_requests.size() > 0) begin
            req_data     <= job_requests.pop_front();
            req_valid    <= 1'b1;
            req_gap_left <= $urandom_range(0, req_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall after each reply for the drawn count; a long hold wins.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (rsp_gap_left > 0) begin
         rsp_ready    <= 1'b0;
         rsp_gap_left <= rsp_gap_left - 1;
      end else if (rsp_taken) begin
         rsp_draw = $urandom_range(0, rsp_gap_max);
         if (rsp_draw > 0) begin
            rsp_ready    <= 1'b0;
            rsp_gap_left <= rsp_draw - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
         held_jobs.delete();
         limit_shadow = QUEUE_LIMIT_RESET;
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_reply("unexpected reply", '0, rsp_data);
            end else begin
               reply_want = expected_replies.pop_front();
               if (rsp_data.status !== reply_want.status ||
                   rsp_data.out_priority !== reply_want.out_priority ||
                   rsp_data.out_compute_time !== reply_want.out_compute_time ||
                   rsp_data.out_job_id !== reply_want.out_job_id ||
                   rsp_data.out_producer !== reply_want.out_producer ||
                   rsp_data.out_process !== reply_want.out_process ||
                   rsp_data.occupancy !== reply_want.occupancy) begin
                  report_reply("reply mismatch", reply_want, rsp_data);
               end
            end
         end
         if (req_valid && req_ready) expected_replies.push_back(predict_reply(req_data));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == LIMIT_ADDR) begin
            limit_shadow = csr_pwdata[LIMIT_W-1:0];
            limit_writes++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [LIMIT_W-1:0] phase_limits [PHASE_COUNT];
      phase_limits = '{7'd127, 7'd64, 7'd1, 7'd5, 7'd0, 7'd100, 7'd64, 7'd2, 7'd40, 7'd12};
      phase_limits[8] = LIMIT_W'($urandom_range(1, DEPTH));
      req_gap_max = STALL_MAX;
      rsp_gap_max = STALL_MAX;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_limit_readback(QUEUE_LIMIT_RESET);

      // remove on an empty queue, then field extremes and priority ties
      job_requests.push_back(job_of(FUNC_REMOVE, 4'd0, 3'd0, 17'd0, 8'd0, 22'd0));
      job_requests.push_back(job_of(FUNC_INSERT, 4'd0, 3'd0, 17'd0, 8'd0, 22'd0));
      job_requests.push_back(job_of(FUNC_INSERT, 4'hF, 3'h7, 17'h1FFFF, 8'hFF, 22'h3FFFFF));
      job_requests.push_back(job_of(FUNC_INSERT, 4'd7, 3'd5, 17'h0AAAA, 8'h55, 22'h2AAAAA));
      job_requests.push_back(job_of(FUNC_INSERT, 4'd7, 3'd2, 17'h15555, 8'hAA, 22'h155555));
      job_requests.push_back(job_of(FUNC_INSERT, 4'hF, 3'd1, 17'h00123, 8'h01, 22'h000321));
      repeat (6) job_requests.push_back(job_of(FUNC_REMOVE, 4'hF, 3'h7, 17'h1FFFF, 8'hFF,
                                               22'h3FFFFF));
      wait_queue_idle();

      // small limit: fill and get refused
      set_queue_limit(7'd2);
      repeat (3) job_requests.push_back(random_job(FUNC_INSERT, 15));
      wait_queue_idle();

      // limit lowered below the held count: refuse inserts, removes still work
      set_queue_limit(7'd1);
      job_requests.push_back(random_job(FUNC_INSERT, 15));
      repeat (3) job_requests.push_back(random_job(FUNC_REMOVE, 15));
      wait_queue_idle();

      // zero limit refuses inserts; the remove finds the queue empty
      set_queue_limit(7'd0);
      job_requests.push_back(random_job(FUNC_INSERT, 15));
      job_requests.push_back(random_job(FUNC_REMOVE, 15));
      wait_queue_idle();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_queue_limit(phase_limits[p]);
         req_gap_max = (p % 3 == 0) ? 0 : STALL_MAX;
         rsp_gap_max = (p % 4 == 2) ? 0 : STALL_MAX;
         queue_random_items(PHASE_ITEMS / 2, 1'b1);
         if (p == 1) begin
            // hold replies off while the sender keeps offering
            @(posedge clock);
            rsp_hold_left = LONG_HOLD;
         end
         // sender pauses here until every reply is back
         wait_queue_idle();
         req_gap_max = STALL_MAX - req_gap_max;
         rsp_gap_max = STALL_MAX - rsp_gap_max;
         queue_random_items(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b0);
         wait_queue_idle();
      end

      repeat (10) @(posedge clock);
      errors += expected_replies.size();
      $display("Covered %0d accepted inserts, %0d refused as full, %0d removes, %0d on empty",
               n_insert, n_full, n_remove, n_empty);
      $display("Peak occupancy %0d of %0d across %0d queue_limit writes",
               peak_occ, DEPTH, limit_writes);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
